>>> hdl/population_fitness_statistics_assert.svh
// Assertion macros shared by the population fitness statistics RTL.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef POPULATION_FITNESS_STATISTICS_ASSERT_SVH
`define POPULATION_FITNESS_STATISTICS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFS_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("population_fitness_statistics: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PFS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("population_fitness_statistics: assertion failed");

`endif

>>> hdl/pfs_pkg.sv
// Package for the population fitness statistics block: widths, register indexes,
// request and result types. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

  // Sizing of the population and the step size lanes.
  localparam int MAX_POPULATION = 1024;
  localparam int SIGMA_LANES    = 4;
  localparam int SIGMA_FIELDS   = 4;
  localparam int LANE_COUNT     = (SIGMA_LANES < SIGMA_FIELDS) ? SIGMA_LANES : SIGMA_FIELDS;

  // Field widths.
  localparam int FIT_W   = 48;
  localparam int SIGMA_W = 32;
  localparam int POS_W   = 10;
  localparam int EVAL_W  = 40;
  localparam int LANES_W = 3;
  localparam int CHILD_W = 11;

  // Derived widths: the count must hold MAX_POPULATION itself.
  localparam int COUNT_W = $clog2(MAX_POPULATION + 1);
  localparam int SUM_W   = FIT_W + COUNT_W - 1;
  localparam int PROD_W  = COUNT_W + CHILD_W;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = CHILD_W;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGMAS_IN_USE       = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHILDREN_PER_PARENT = 1'd1;

  // One individual.
  typedef struct packed {
    logic                    fit_valid;
    logic signed [FIT_W-1:0] fit_value;
    logic [SIGMA_W-1:0]      sigma_0;
    logic [SIGMA_W-1:0]      sigma_1;
    logic [SIGMA_W-1:0]      sigma_2;
    logic [SIGMA_W-1:0]      sigma_3;
    logic                    last_in_generation;
    logic                    first_generation;
  } in_item_t;

  // One generation summary.
  typedef struct packed {
    logic                    best_valid;
    logic signed [FIT_W-1:0] best_value;
    logic [POS_W-1:0]        best_position;
    logic                    worst_valid;
    logic signed [FIT_W-1:0] worst_value;
    logic signed [FIT_W-1:0] mean_value;
    logic [SIGMA_W-1:0]      sigma_min;
    logic [SIGMA_W-1:0]      sigma_max;
    logic [EVAL_W-1:0]       evaluations_total;
    logic                    record_improved;
    logic                    record_valid;
    logic signed [FIT_W-1:0] record_value;
  } out_item_t;

  // Candidates one lane offers to the min and max merge.
  typedef struct packed {
    logic [SIGMA_W-1:0] lo;
    logic [SIGMA_W-1:0] hi;
  } lane_cand_t;

endpackage

`default_nettype wire

>>> hdl/pfs_if.sv
// Valid/ready channel interfaces for individuals in and generation summaries out.
// Depends on pfs_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface pfs_in_if;
  logic             valid;
  logic             ready;
  pfs_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pfs_out_if;
  logic               valid;
  logic               ready;
  pfs_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/population_fitness_statistics.sv
// Population fitness statistics. Individuals stream in at one request per cycle; each
// updates the generation's best and worst (valid beats invalid, lower wins, first seen
// kept on ties), the fitness sum and count, and the step size extremes over the lanes
// in use, which four side-by-side lanes and a merge stage track. The request marked
// last in its generation, or the one that fills MAX_POPULATION, closes the generation:
// input stays not ready through the closing state, the divider's steps and the loading
// of the summary, and longer while an earlier summary still waits in the output register.
// A one-bit-per-cycle divider forms the mean, then one summary is placed in the output
// register, the saturating evaluation total and the best-so-far record having been
// updated. The next generation may stream in while that summary waits to be taken. The
// user must write configuration only while the block is idle; the block itself does not
// enforce it.
`timescale 1ns / 1ps
`default_nettype none
`include "population_fitness_statistics_assert.svh"

module population_fitness_statistics (
  input  logic                            clk,
  input  logic                            rst,
  pfs_in_if.sink                          items,
  pfs_out_if.source                       results,
  input  logic                            cfg_write,
  input  logic [pfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CLOSE = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  localparam int FIT_W   = pfs_pkg::FIT_W;
  localparam int COUNT_W = pfs_pkg::COUNT_W;
  localparam int SUM_W   = pfs_pkg::SUM_W;
  localparam int EVAL_W  = pfs_pkg::EVAL_W;
  localparam int LANES_W = pfs_pkg::LANES_W;

  // True if (av, a) is strictly better than (bv, b).
  function automatic logic wins(input logic av, input logic signed [FIT_W-1:0] a,
                                input logic bv, input logic signed [FIT_W-1:0] b);
    if (av == bv) return a < b;
    return av;
  endfunction

  logic [1:0]                    state;
  logic [LANES_W-1:0]            sigmas_in_use;
  logic [pfs_pkg::CHILD_W-1:0]   children_per_parent;

  logic                          best_valid;
  logic signed [FIT_W-1:0]       best_value;
  logic [pfs_pkg::POS_W-1:0]     best_position;
  logic                          worst_valid;
  logic signed [FIT_W-1:0]       worst_value;
  logic [SUM_W-1:0]              fitness_sum;
  logic [COUNT_W-1:0]            item_count;
  logic [EVAL_W-1:0]             evaluation_count;
  logic                          record_valid;
  logic signed [FIT_W-1:0]       record_value;
  logic                          record_improved;
  logic                          close_first;
  logic                          mean_neg;
  logic [pfs_pkg::PROD_W-1:0]    eval_add;

  logic                          out_valid;
  pfs_pkg::out_item_t            out_reg;

  logic                          item_accept;
  logic                          close_item;
  logic                          emit_go;
  logic [31:0]                   count_ext;
  logic [SUM_W-1:0]              fit_ext;
  logic [SUM_W-1:0]              sum_mag;
  logic [EVAL_W:0]               eval_sum;
  logic                          improved_now;
  logic [FIT_W-1:0]              quot_low;
  logic                          record_same;

  logic [LANES_W-1:0]            lanes_eff;
  logic [pfs_pkg::LANE_COUNT-1:0] lane_used;
  logic                          lane_valid;
  logic [pfs_pkg::SIGMA_W-1:0]   sigma_field [pfs_pkg::SIGMA_FIELDS];
  pfs_pkg::lane_cand_t [pfs_pkg::LANE_COUNT-1:0] cands;
  logic                          sigma_pending;
  logic [pfs_pkg::SIGMA_W-1:0]   step_min;
  logic [pfs_pkg::SIGMA_W-1:0]   step_max;

  logic [SUM_W-1:0]              div_quotient;
  logic                          div_busy;
  logic                          div_done;

  // Handshake and closing conditions.
  assign items.ready = (state == S_IDLE);
  assign item_accept = items.valid && items.ready;
  assign close_item  = items.data.last_in_generation ||
                       (item_count == COUNT_W'(pfs_pkg::MAX_POPULATION - 1));
  assign emit_go     = (state == S_EMIT) && (!out_valid || results.ready);

  // Helper values for the datapath.
  assign count_ext    = 32'(item_count);
  assign fit_ext      = {{(SUM_W-FIT_W){items.data.fit_value[FIT_W-1]}}, items.data.fit_value};
  assign sum_mag      = fitness_sum[SUM_W-1] ? (~fitness_sum + 1'b1) : fitness_sum;
  assign eval_sum     = {1'b0, evaluation_count} + (EVAL_W+1)'(eval_add);
  assign improved_now = close_first || wins(best_valid, best_value, record_valid, record_value);
  assign quot_low     = div_quotient[FIT_W-1:0];

  // Control: state, configuration, counters and the record.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= S_IDLE;
      sigmas_in_use       <= LANES_W'(1);
      children_per_parent <= pfs_pkg::CHILD_W'(1);
      item_count          <= '0;
      fitness_sum         <= '0;
      evaluation_count    <= '0;
      record_valid        <= 1'b0;
      record_value        <= '0;
      lane_valid          <= 1'b0;
    end else begin
      lane_valid <= item_accept;
      if (cfg_write) begin
        unique case (cfg_index)
          pfs_pkg::CFG_SIGMAS_IN_USE:       sigmas_in_use <= cfg_data[LANES_W-1:0];
          pfs_pkg::CFG_CHILDREN_PER_PARENT: children_per_parent <= cfg_data;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (item_accept) begin
            item_count  <= item_count + 1'b1;
            fitness_sum <= fitness_sum + fit_ext;
            if (close_item) state <= S_CLOSE;
          end
        end
        S_CLOSE: begin
          if (improved_now) begin
            record_valid <= best_valid;
            record_value <= best_value;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            evaluation_count <= eval_sum[EVAL_W] ? '1 : eval_sum[EVAL_W-1:0];
            state            <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            item_count  <= '0;
            fitness_sum <= '0;
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

  // Best and worst of the generation; the first request of a generation seeds both.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      close_first <= items.data.first_generation;
      if (item_count == '0) begin
        best_valid    <= items.data.fit_valid;
        best_value    <= items.data.fit_value;
        best_position <= '0;
        worst_valid   <= items.data.fit_valid;
        worst_value   <= items.data.fit_value;
      end else begin
        if (wins(items.data.fit_valid, items.data.fit_value, best_valid, best_value)) begin
          best_valid    <= items.data.fit_valid;
          best_value    <= items.data.fit_value;
          best_position <= count_ext[pfs_pkg::POS_W-1:0];
        end
        if (wins(worst_valid, worst_value, items.data.fit_valid, items.data.fit_value)) begin
          worst_valid <= items.data.fit_valid;
          worst_value <= items.data.fit_value;
        end
      end
    end
  end

  // Closing work that the divider runs beside.
  always_ff @(posedge clk) begin
    if (state == S_CLOSE) begin
      eval_add        <= item_count * children_per_parent;
      mean_neg        <= fitness_sum[SUM_W-1];
      record_improved <= improved_now;
    end
  end

  // Output register: decouples the summary from the next generation's input.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_reg.best_valid        <= best_valid;
      out_reg.best_value        <= best_value;
      out_reg.best_position     <= best_position;
      out_reg.worst_valid       <= worst_valid;
      out_reg.worst_value       <= worst_value;
      out_reg.mean_value        <= mean_neg ? (~quot_low + 1'b1) : quot_low;
      out_reg.sigma_min         <= step_min;
      out_reg.sigma_max         <= step_max;
      out_reg.evaluations_total <= evaluation_count;
      out_reg.record_improved   <= record_improved;
      out_reg.record_valid      <= record_valid;
      out_reg.record_value      <= record_value;
    end
  end

  assign results.valid = out_valid;
  assign results.data  = out_reg;

  // Effective lane count: zero acts as one, too many acts as the lanes there are.
  always_comb begin
    lanes_eff = sigmas_in_use;
    if (sigmas_in_use == '0) begin
      lanes_eff = LANES_W'(1);
    end else if (sigmas_in_use > LANES_W'(pfs_pkg::LANE_COUNT)) begin
      lanes_eff = LANES_W'(pfs_pkg::LANE_COUNT);
    end
  end

  assign sigma_field[0] = items.data.sigma_0;
  assign sigma_field[1] = items.data.sigma_1;
  assign sigma_field[2] = items.data.sigma_2;
  assign sigma_field[3] = items.data.sigma_3;

  // Step size lanes.
  for (genvar k = 0; k < pfs_pkg::LANE_COUNT; k++) begin : g_lane
    assign lane_used[k] = LANES_W'(k) < lanes_eff;

    pfs_sigma_lane u_lane (
      .clk   (clk),
      .load  (item_accept),
      .used  (lane_used[k]),
      .sigma (sigma_field[k]),
      .cand  (cands[k])
    );
  end

  pfs_sigma_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .lane_valid (lane_valid),
    .clear      (emit_go),
    .cands      (cands),
    .pending    (sigma_pending),
    .step_min   (step_min),
    .step_max   (step_max)
  );

  // Mean magnitude: |sum| / count.
  pfs_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_CLOSE),
    .dividend (sum_mag),
    .divisor  (item_count),
    .quotient (div_quotient),
    .busy     (div_busy),
    .done     (div_done)
  );

  // The summary's record fields agree with its best individual.
  assign record_same = (out_reg.record_valid == out_reg.best_valid) &&
                       (out_reg.record_value == out_reg.best_value);

  // The step size pipeline has drained before the summary is built.
  `PFS_ASSERT_NOW(a_sigma_drained, div_done, !lane_valid && !sigma_pending && !div_busy)
  // A generation never holds more than the population limit while streaming.
  `PFS_ASSERT_NOW(a_count_bound, state == S_IDLE, item_count < COUNT_W'(pfs_pkg::MAX_POPULATION))
  // Emitting a summary starts a fresh generation.
  `PFS_ASSERT_NEXT(a_gen_cleared, emit_go, state == S_IDLE && item_count == '0 && fitness_sum == '0)
  // An improved record equals the generation's best.
  `PFS_ASSERT_NOW(a_record_match, out_valid && out_reg.record_improved, record_same)

endmodule

`default_nettype wire

>>> hdl/pfs_sigma_lane.sv
// One step size lane: registers the lane's min and max candidates for a request.
// Depends on pfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfs_sigma_lane (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         used,
  input  logic [pfs_pkg::SIGMA_W-1:0]  sigma,
  output pfs_pkg::lane_cand_t          cand
);

  // A lane that is not in use offers the neutral value to both reductions.
  always_ff @(posedge clk) begin
    if (load) begin
      cand.lo <= used ? sigma : '1;
      cand.hi <= used ? sigma : '0;
    end
  end

endmodule

`default_nettype wire

>>> hdl/pfs_sigma_merge.sv
// Merges the lane candidates into the per-generation smallest and largest step size.
// Depends on pfs_pkg; fed by the pfs_sigma_lane instances.
`timescale 1ns / 1ps
`default_nettype none

module pfs_sigma_merge (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             lane_valid,
  input  logic                                             clear,
  input  pfs_pkg::lane_cand_t [pfs_pkg::LANE_COUNT-1:0]    cands,
  output logic                                             pending,
  output logic [pfs_pkg::SIGMA_W-1:0]                      step_min,
  output logic [pfs_pkg::SIGMA_W-1:0]                      step_max
);

  logic [pfs_pkg::SIGMA_W-1:0] red_lo;
  logic [pfs_pkg::SIGMA_W-1:0] red_hi;
  logic [pfs_pkg::SIGMA_W-1:0] item_lo;
  logic [pfs_pkg::SIGMA_W-1:0] item_hi;
  logic                        item_valid;

  // Reduce the lanes of one request to its own extremes.
  always_comb begin
    red_lo = '1;
    red_hi = '0;
    for (int i = 0; i < pfs_pkg::LANE_COUNT; i++) begin
      if (cands[i].lo < red_lo) red_lo = cands[i].lo;
      if (cands[i].hi > red_hi) red_hi = cands[i].hi;
    end
  end

  // Stage register between the lane reduction and the running fold.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      item_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lane_valid) begin
      item_lo <= red_lo;
      item_hi <= red_hi;
    end
  end

  // Fold into the running extremes; a new generation starts from the neutral values.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      step_min <= '1;
      step_max <= '0;
    end else if (item_valid) begin
      if (item_lo < step_min) step_min <= item_lo;
      if (item_hi > step_max) step_max <= item_hi;
    end
  end

  assign pending = item_valid;

endmodule

`default_nettype wire

>>> hdl/pfs_divider.sv
// Restoring divider, one quotient bit per cycle, for the generation mean.
// Depends on pfs_pkg for the sum and count widths.
`timescale 1ns / 1ps
`default_nettype none

module pfs_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pfs_pkg::SUM_W-1:0]   dividend,
  input  logic [pfs_pkg::COUNT_W-1:0] divisor,
  output logic [pfs_pkg::SUM_W-1:0]   quotient,
  output logic                        busy,
  output logic                        done
);

  localparam int STEP_W = $clog2(pfs_pkg::SUM_W + 1);

  logic [pfs_pkg::SUM_W-1:0]   acc;
  logic [pfs_pkg::COUNT_W-1:0] rem;
  logic [pfs_pkg::COUNT_W-1:0] dvs;
  logic [STEP_W-1:0]           steps_left;
  logic [pfs_pkg::COUNT_W:0]   trial;
  logic                        fits;
  logic [pfs_pkg::COUNT_W:0]   trial_sub;

  // One trial subtraction of the shifted remainder.
  always_comb begin
    trial     = {rem, acc[pfs_pkg::SUM_W-1]};
    fits      = trial >= {1'b0, dvs};
    trial_sub = trial - {1'b0, dvs};
  end

  // Control: count the steps and flag the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      steps_left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy       <= 1'b1;
        steps_left <= STEP_W'(pfs_pkg::SUM_W);
      end else if (busy) begin
        steps_left <= steps_left - 1'b1;
        if (steps_left == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend shifts out as the quotient shifts in.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      acc <= {acc[pfs_pkg::SUM_W-2:0], fits};
      rem <= fits ? trial_sub[pfs_pkg::COUNT_W-1:0] : trial[pfs_pkg::COUNT_W-1:0];
    end
  end

  assign quotient = acc;

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for population_fitness_statistics: streams individuals, predicts
// each generation summary in a model of its own, and checks every field of every summary.
// Depends on pfs_pkg and the pfs_in_if / pfs_out_if interfaces from the RTL.
`timescale 1ns / 1ps

module tb;
  import pfs_pkg::*;

  localparam logic signed [FIT_W-1:0] FIT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [FIT_W-1:0] FIT_MIN = 48'sh8000_0000_0000;
  localparam logic [SIGMA_W-1:0] SIGMA_ALL = 32'hFFFF_FFFF;
  localparam logic [SIGMA_W-1:0] UNIT_STEP = 32'h0001_0000;
  localparam logic [EVAL_W-1:0] EVAL_MAX = '1;
  localparam int SETTLE_CYCLES = 80;
  localparam int DRAIN_LIMIT = 20000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 55;
  localparam int FULL_PHASE = 5;

  // One row of the directed table: the individual, and where it closes a generation with
  // an obvious outcome, the summary written out by hand.
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pfs_in_if  items_ch ();
  pfs_out_if results_ch ();

  population_fitness_statistics DUT (
    .clk       (clk),
    .rst       (rst),
    .items     (items_ch),
    .results   (results_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted configuration and generation state.
  logic [LANES_W-1:0] lanes_reg;
  logic [CHILD_W-1:0] children_reg;
  logic gen_best_ok;
  logic signed [FIT_W-1:0] gen_best_fit;
  logic [POS_W-1:0] gen_best_pos;
  logic gen_worst_ok;
  logic signed [FIT_W-1:0] gen_worst_fit;
  longint fit_sum;
  int unsigned members_seen;
  logic [SIGMA_W-1:0] step_lo;
  logic [SIGMA_W-1:0] step_hi;
  logic [EVAL_W-1:0] eval_total;
  logic record_ok;
  logic signed [FIT_W-1:0] record_fit;

  out_item_t expected_summaries[$];
  dir_row_t directed_rows[$];
  int mismatch_count = 0;
  bit idling_on = 1'b1;
  int ready_hold = 0;
  logic signed [FIT_W-1:0] prev_fit = '0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // True when (av, a) ranks strictly above (bv, b): valid first, then the lower value.
  function automatic bit outranks(input logic av, input logic signed [FIT_W-1:0] a,
                                  input logic bv, input logic signed [FIT_W-1:0] b);
    if (av == bv) return a < b;
    return av;
  endfunction

  function automatic void clear_generation();
    gen_best_ok = 1'b0;
    gen_best_fit = '0;
    gen_best_pos = '0;
    gen_worst_ok = 1'b0;
    gen_worst_fit = '0;
    fit_sum = 0;
    members_seen = 0;
    step_lo = '1;
    step_hi = '0;
  endfunction

  // Folds one accepted individual into the predicted state. Returns 1 and the summary
  // when the individual closes its generation.
  function automatic bit fold_individual(input in_item_t it, output out_item_t res);
    int lanes;
    logic [SIGMA_W-1:0] steps [4];
    longint fv;
    longint unsigned evals;
    bit improved;
    res = '0;
    lanes = int'(lanes_reg);
    if (lanes < 1) lanes = 1;
    if (lanes > SIGMA_LANES) lanes = SIGMA_LANES;
    if (lanes > 4) lanes = 4;
    steps[0] = it.sigma_0;
    steps[1] = it.sigma_1;
    steps[2] = it.sigma_2;
    steps[3] = it.sigma_3;
    fv = it.fit_value;

    // The first member seeds best and worst; later ones keep the first seen on ties.
    if (members_seen == 0) begin
      gen_best_ok = it.fit_valid;
      gen_best_fit = it.fit_value;
      gen_best_pos = '0;
      gen_worst_ok = it.fit_valid;
      gen_worst_fit = it.fit_value;
    end else begin
      if (outranks(it.fit_valid, it.fit_value, gen_best_ok, gen_best_fit)) begin
        gen_best_ok = it.fit_valid;
        gen_best_fit = it.fit_value;
        gen_best_pos = POS_W'(members_seen);
      end
      if (outranks(gen_worst_ok, gen_worst_fit, it.fit_valid, it.fit_value)) begin
        gen_worst_ok = it.fit_valid;
        gen_worst_fit = it.fit_value;
      end
    end
    fit_sum += fv;
    for (int k = 0; k < lanes; k++) begin
      if (steps[k] < step_lo) step_lo = steps[k];
      if (steps[k] > step_hi) step_hi = steps[k];
    end
    members_seen++;

    // A full population closes the generation even without the last marker.
    if (!it.last_in_generation && members_seen < MAX_POPULATION) return 1'b0;

    evals = 64'(eval_total) + 64'(members_seen) * 64'(children_reg);
    eval_total = (evals > 64'(EVAL_MAX)) ? EVAL_MAX : evals[EVAL_W-1:0];
    improved = it.first_generation ||
               outranks(gen_best_ok, gen_best_fit, record_ok, record_fit);
    if (improved) begin
      record_ok = gen_best_ok;
      record_fit = gen_best_fit;
    end

    res.best_valid = gen_best_ok;
    res.best_value = gen_best_fit;
    res.best_position = gen_best_pos;
    res.worst_valid = gen_worst_ok;
    res.worst_value = gen_worst_fit;
    res.mean_value = FIT_W'(fit_sum / longint'(members_seen));
    res.sigma_min = step_lo;
    res.sigma_max = step_hi;
    res.evaluations_total = eval_total;
    res.record_improved = improved;
    res.record_valid = record_ok;
    res.record_value = record_fit;
    clear_generation();
    return 1'b1;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
  endtask

  // Idle lengths: mostly short, now and then a long stretch.
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int sender_gap();
    if (!idling_on || $urandom_range(0, 1) == 0) return 0;
    return pick_gap();
  endfunction

  function automatic logic [SIGMA_W-1:0] random_step();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SIGMA_ALL;
      2: return UNIT_STEP + SIGMA_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // Random individual: extremes, small values that tie often, repeats, and full-range values.
  function automatic in_item_t random_individual(input bit last);
    in_item_t it;
    it.fit_valid = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 7))
      0: it.fit_value = $urandom_range(0, 1) ? FIT_MAX : FIT_MIN;
      1, 2: it.fit_value = FIT_W'(int'($urandom_range(0, 16)) - 8);
      3: it.fit_value = prev_fit;
      default: it.fit_value = FIT_W'({$urandom, $urandom});
    endcase
    prev_fit = it.fit_value;
    it.sigma_0 = random_step();
    it.sigma_1 = random_step();
    it.sigma_2 = random_step();
    it.sigma_3 = random_step();
    it.last_in_generation = last;
    it.first_generation = ($urandom_range(0, 9) == 0);
    return it;
  endfunction

  // Sends one request and, once accepted, records the summary it is predicted to close.
  task automatic send_individual(input in_item_t it, input bit typed, input out_item_t want);
    int gap;
    out_item_t res;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.data <= it;
    do @(posedge clk); while (!items_ch.ready);
    if (fold_individual(it, res)) expected_summaries.push_back(typed ? want : res);
  endtask

  // Stops sending, waits for every outstanding summary, then lets the divider settle.
  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    items_ch.valid <= 1'b0;
    while (expected_summaries.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_summaries.size() != 0) begin
      report("summaries never received", expected_summaries.size(), 0);
      expected_summaries.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int lanes_raw, input int children_raw);
    logic [CFG_DATA_W-1:0] lanes_word;
    lanes_word = {8'($urandom), 3'(lanes_raw)};
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SIGMAS_IN_USE;
    cfg_data <= lanes_word;
    @(posedge clk);
    lanes_reg = lanes_word[LANES_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_CHILDREN_PER_PARENT;
    cfg_data <= CFG_DATA_W'(children_raw);
    @(posedge clk);
    children_reg = CHILD_W'(children_raw);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic add_row(input in_item_t it, input bit typed, input out_item_t want);
    dir_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // Result side: random back-pressure, with calm phases that never stall.
  always @(negedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else if (!idling_on) begin
      results_ch.ready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      results_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      ready_hold = pick_gap() - 1;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= 1'b1;
    end
  end

  // Compare every accepted summary with the oldest prediction.
  always @(posedge clk) begin : summary_check
    out_item_t got;
    out_item_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      got = results_ch.data;
      if (expected_summaries.size() == 0) begin
        report("summary with none expected", got.best_value, 0);
      end else begin
        want = expected_summaries.pop_front();
        if (got.best_valid !== want.best_valid)
          report("best_valid", got.best_valid, want.best_valid);
        if (got.best_value !== want.best_value)
          report("best_value", got.best_value, want.best_value);
        if (got.best_position !== want.best_position)
          report("best_position", got.best_position, want.best_position);
        if (got.worst_valid !== want.worst_valid)
          report("worst_valid", got.worst_valid, want.worst_valid);
        if (got.worst_value !== want.worst_value)
          report("worst_value", got.worst_value, want.worst_value);
        if (got.mean_value !== want.mean_value)
          report("mean_value", got.mean_value, want.mean_value);
        if (got.sigma_min !== want.sigma_min)
          report("sigma_min", got.sigma_min, want.sigma_min);
        if (got.sigma_max !== want.sigma_max)
          report("sigma_max", got.sigma_max, want.sigma_max);
        if (got.evaluations_total !== want.evaluations_total)
          report("evaluations_total", got.evaluations_total, want.evaluations_total);
        if (got.record_improved !== want.record_improved)
          report("record_improved", got.record_improved, want.record_improved);
        if (got.record_valid !== want.record_valid)
          report("record_valid", got.record_valid, want.record_valid);
        if (got.record_value !== want.record_value)
          report("record_value", got.record_value, want.record_value);
      end
    end
  end

  // Main sequence: reset, directed table, then randomized phases under varying settings.
  initial begin
    int lanes_plan [PHASES];
    int children_plan [PHASES];
    int sent;
    int gen_size;
    out_item_t none;

    rst = 1'b1;
    items_ch.valid = 1'b0;
    items_ch.data = '0;
    results_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    none = '0;
    lanes_reg = 3'd1;
    children_reg = 11'd1;
    eval_total = '0;
    record_ok = 1'b0;
    record_fit = '0;
    clear_generation();
    lanes_plan = '{1, 4, 0, 7, 2, 3, 5, 6, 4, 1};
    children_plan = '{1, 1024, 0, 2047, 5, -1, -1, 1, -1, 2};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Single-member generations at the fitness extremes, one lane in use.
    add_row('{1'b1, FIT_MAX, UNIT_STEP, UNIT_STEP, UNIT_STEP, UNIT_STEP, 1'b1, 1'b1}, 1'b1,
            '{1'b1, FIT_MAX, 10'd0, 1'b1, FIT_MAX, FIT_MAX, UNIT_STEP, UNIT_STEP,
              40'd1, 1'b1, 1'b1, FIT_MAX});
    add_row('{1'b0, FIT_MIN, 32'd0, SIGMA_ALL, SIGMA_ALL, SIGMA_ALL, 1'b1, 1'b0}, 1'b1,
            '{1'b0, FIT_MIN, 10'd0, 1'b0, FIT_MIN, FIT_MIN, 32'd0, 32'd0,
              40'd2, 1'b0, 1'b1, FIT_MAX});
    // Ties the record exactly, so the record is kept.
    add_row('{1'b1, FIT_MAX, SIGMA_ALL, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b1,
            '{1'b1, FIT_MAX, 10'd0, 1'b1, FIT_MAX, FIT_MAX, SIGMA_ALL, SIGMA_ALL,
              40'd3, 1'b0, 1'b1, FIT_MAX});
    // Mixed validity with ties on best and worst.
    add_row('{1'b0, -48'sd5, 32'h0002_0000, 32'd1, 32'd1, 32'd1, 1'b0, 1'b0}, 1'b0, none);
    add_row('{1'b1, 48'sd100, 32'h0000_8000, 32'd1, 32'd1, 32'd1, 1'b0, 1'b1}, 1'b0, none);
    add_row('{1'b1, 48'sd100, 32'h0003_0000, 32'd1, 32'd1, 32'd1, 1'b0, 1'b0}, 1'b0, none);
    add_row('{1'b1, -48'sd1, 32'h0001_0000, 32'd1, 32'd1, 32'd1, 1'b0, 1'b0}, 1'b0, none);
    add_row('{1'b0, -48'sd5, 32'h0001_8000, 32'd1, 32'd1, 32'd1, 1'b1, 1'b0}, 1'b0, none);
    // Negative mean that truncates toward zero.
    add_row('{1'b1, -48'sd7, UNIT_STEP, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b0, none);
    add_row('{1'b1, 48'sd0, UNIT_STEP, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1}, 1'b0, none);
    // Generation zero forces an invalid record; a valid one then replaces it.
    add_row('{1'b0, 48'sd5, 32'd7, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1}, 1'b0, none);
    add_row('{1'b1, FIT_MAX, 32'd9, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, none);
    // Best arrives last; the generation-zero flag on an inner member has no effect.
    add_row('{1'b1, 48'sd3, 32'd4, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1}, 1'b0, none);
    add_row('{1'b1, 48'sd9, 32'd2, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0}, 1'b0, none);
    add_row('{1'b1, 48'sd2, 32'd6, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0}, 1'b0, none);

    foreach (directed_rows[i])
      send_individual(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      idling_on = (p % 4 != 1);
      set_config(lanes_plan[p],
                 (children_plan[p] < 0) ? int'($urandom_range(1, 1024)) : children_plan[p]);
      if (p == FULL_PHASE) begin
        // A full population with no last marker anywhere.
        for (int i = 0; i < MAX_POPULATION; i++)
          send_individual(random_individual(1'b0), 1'b0, none);
      end else begin
        sent = 0;
        while (sent < PHASE_ITEMS) begin
          gen_size = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 40);
          for (int i = 0; i < gen_size; i++)
            send_individual(random_individual(i == gen_size - 1), 1'b0, none);
          sent += gen_size;
        end
      end
      drain();
    end

    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #30_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
